>>> rtl/tbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbl_pkg;

	// result status codes
	localparam logic [2:0] ST_STARTED = 3'd0;
	localparam logic [2:0] ST_DRAWN   = 3'd1;
	localparam logic [2:0] ST_CURSOR  = 3'd2;
	localparam logic [2:0] ST_STOP    = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_SCALE_X      = 3'd0;
	localparam logic [2:0] REG_SCALE_Y      = 3'd1;
	localparam logic [2:0] REG_WRAP_ENABLE  = 3'd2;
	localparam logic [2:0] REG_FONT_MODE    = 3'd3;
	localparam logic [2:0] REG_LINE_ADVANCE = 3'd4;
	localparam logic [2:0] REG_FIRST_CODE   = 3'd5;
	localparam logic [2:0] REG_LAST_CODE    = 3'd6;

	localparam logic [7:0] NL_CODE   = 8'd10;
	localparam logic [7:0] CR_CODE   = 8'd13;
	localparam logic [7:0] CLASSIC_W = 8'd6;
	localparam logic [7:0] CLASSIC_H = 8'd8;

	typedef struct packed {
		logic [7:0] scale_x;
		logic [7:0] scale_y;
		logic       wrap_enable;
		logic       font_mode;
		logic [7:0] line_advance;
		logic [7:0] first_code;
		logic [7:0] last_code;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic        [15:0] origin_x;
		logic        [15:0] origin_y;
		logic        [14:0] box_width;
		logic        [14:0] box_height;
		logic        [7:0]  char_code;
		logic        [7:0]  glyph_width;
		logic        [7:0]  glyph_height;
		logic        [7:0]  glyph_x_offset;
		logic        [7:0]  glyph_x_advance;
	} item_t;

	typedef struct packed {
		logic [15:0] cursor_x;
		logic [15:0] cursor_y;
		logic [15:0] left_edge;
		logic [17:0] right_edge;
		logic [17:0] bottom_edge;
		logic        halted;
	} state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] draw_x;
		logic [15:0] draw_y;
		logic [7:0]  draw_code;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/tbl_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One layout step: result and next cursor state for one word.
module tbl_step (
	input  var tbl_pkg::item_t   it,
	input  var tbl_pkg::state_t  st,
	input  var tbl_pkg::cfg_t    cfg,
	input  wire logic [15:0]     line_h,
	input  wire logic [10:0]     classic_adv,
	output tbl_pkg::result_t     res,
	output tbl_pkg::state_t      nxt
);

	logic               is_nl, is_cr, out_of_font, drawable;
	logic        [15:0] adv_p;
	logic signed [9:0]  xo_w;
	logic signed [18:0] reach_p;
	logic        [15:0] adv;
	logic signed [19:0] reach;
	logic        [15:0] cy_nl;
	logic signed [19:0] cx_reach;
	logic               wrap_hit, bot_cur, bot_nl, stop_hit;
	logic        [15:0] cx1, cy1;

	assign is_nl = it.char_code == tbl_pkg::NL_CODE;
	assign is_cr = it.char_code == tbl_pkg::CR_CODE;
	assign out_of_font = cfg.font_mode &&
		((it.char_code < cfg.first_code) || (it.char_code > cfg.last_code));
	assign drawable = !cfg.font_mode ||
		((it.glyph_width != 8'd0) && (it.glyph_height != 8'd0));

	assign adv_p = 16'(it.glyph_x_advance) * 16'(cfg.scale_x);
	assign xo_w = {{2{it.glyph_x_offset[7]}}, it.glyph_x_offset} + $signed({2'b00, it.glyph_width});
	assign reach_p = $signed({11'd0, cfg.scale_x}) * 19'(xo_w);

	assign adv = cfg.font_mode ? adv_p : {5'd0, classic_adv};
	assign reach = cfg.font_mode ? {reach_p[18], reach_p} : $signed({9'd0, classic_adv});

	assign cy_nl = st.cursor_y + line_h;

	assign cx_reach = $signed({{4{st.cursor_x[15]}}, st.cursor_x}) + reach;
	assign wrap_hit = cfg.wrap_enable && (cx_reach > $signed({{2{st.right_edge[17]}}, st.right_edge}));
	assign bot_cur = ($signed({{4{st.cursor_y[15]}}, st.cursor_y}) + $signed({4'd0, line_h}))
		> $signed({{2{st.bottom_edge[17]}}, st.bottom_edge});
	assign bot_nl = ($signed({{4{cy_nl[15]}}, cy_nl}) + $signed({4'd0, line_h}))
		> $signed({{2{st.bottom_edge[17]}}, st.bottom_edge});
	assign stop_hit = wrap_hit ? bot_nl : bot_cur;
	assign cx1 = wrap_hit ? st.left_edge : st.cursor_x;
	assign cy1 = wrap_hit ? cy_nl : st.cursor_y;

	always_comb begin
		nxt = st;
		res.status = tbl_pkg::ST_CURSOR;
		res.draw_x = '0;
		res.draw_y = '0;
		res.draw_code = it.char_code;
		if (!it.kind) begin
			nxt.left_edge = it.origin_x;
			nxt.cursor_x = it.origin_x;
			nxt.cursor_y = it.origin_y;
			nxt.right_edge = {{2{it.origin_x[15]}}, it.origin_x} + {3'd0, it.box_width};
			nxt.bottom_edge = {{2{it.origin_y[15]}}, it.origin_y} + {3'd0, it.box_height};
			nxt.halted = 1'b0;
			res.status = tbl_pkg::ST_STARTED;
			res.draw_code = '0;
		end else if (st.halted) begin
			res.status = tbl_pkg::ST_IGNORED;
		end else if (is_nl) begin
			nxt.cursor_x = st.left_edge;
			nxt.cursor_y = cy_nl;
		end else if (is_cr || out_of_font) begin
			nxt = st;
		end else if (drawable) begin
			// a wrap moves the cursor even when the word then overflows
			nxt.cursor_x = cx1;
			nxt.cursor_y = cy1;
			if (stop_hit) begin
				nxt.halted = 1'b1;
				res.status = tbl_pkg::ST_STOP;
			end else begin
				res.status = tbl_pkg::ST_DRAWN;
				res.draw_x = cx1;
				res.draw_y = cy1;
				nxt.cursor_x = cx1 + adv;
			end
		end else begin
			nxt.cursor_x = st.cursor_x + adv;
		end
	end

endmodule

`default_nettype wire

>>> rtl/text_box_layout_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Text box layout core.
// Input stream (s_*): one word per start or character item; s_tuser is the kind
// (0 starts a box, 1 is a character), s_tdata carries box and glyph fields.
// Output stream (m_*): exactly one result word per input word, in order;
// m_tuser is the status, m_tdata the draw position and echoed code.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the user
// must write only while the stream is idle, which the core does not enforce.
// Pipeline: input register, then the layout step into the output register.
// Throughput: one word per cycle unless the output stalls; the cursor state is
// updated in the same cycle as the step, so the next word sees it without a bubble.
// Reset: clears both stages and puts the layout in the halted state, so
// characters answer "ignored" until the first start word.
// Stall: when m_tready is low the result is held, the input register fills,
// and s_tready drops only once both are occupied.
module text_box_layout_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [15:0] origin_x, [31:16] origin_y, [46:32] box_width, [61:47] box_height,
	// [69:62] char_code, [77:70] glyph_width, [85:78] glyph_height,
	// [93:86] glyph_x_offset, [101:94] glyph_x_advance, [103:102] zero
	input  wire logic [103:0] s_tdata,
	// [0] kind
	input  wire logic         s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [15:0] draw_x, [31:16] draw_y, [39:32] draw_code
	output logic [39:0]       m_tdata,
	// [2:0] status
	output logic [2:0]        m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [7:0]   cfg_data
);

	tbl_pkg::cfg_t    cfg_q;
	tbl_pkg::state_t  st_q, st_nxt;
	tbl_pkg::item_t   item_s1;
	tbl_pkg::result_t res_c, res_q;
	logic             valid_s1, valid_q;
	logic             out_free, adv_s1;
	logic [15:0]      line_h_q;
	logic [10:0]      classic_adv_q;

	assign out_free = !valid_q || m_tready;
	assign adv_s1 = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_x <= 8'd1;
			cfg_q.scale_y <= 8'd1;
			cfg_q.wrap_enable <= 1'b1;
			cfg_q.font_mode <= 1'b0;
			cfg_q.line_advance <= 8'd8;
			cfg_q.first_code <= 8'd32;
			cfg_q.last_code <= 8'd126;
		end else if (cfg_we) begin
			case (cfg_index)
				tbl_pkg::REG_SCALE_X:      cfg_q.scale_x <= cfg_data;
				tbl_pkg::REG_SCALE_Y:      cfg_q.scale_y <= cfg_data;
				tbl_pkg::REG_WRAP_ENABLE:  cfg_q.wrap_enable <= cfg_data[0];
				tbl_pkg::REG_FONT_MODE:    cfg_q.font_mode <= cfg_data[0];
				tbl_pkg::REG_LINE_ADVANCE: cfg_q.line_advance <= cfg_data;
				tbl_pkg::REG_FIRST_CODE:   cfg_q.first_code <= cfg_data;
				tbl_pkg::REG_LAST_CODE:    cfg_q.last_code <= cfg_data;
				default: ;
			endcase
		end
	end

	// config-only products, registered from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_h_q <= 16'd8;
			classic_adv_q <= 11'd6;
		end else begin
			line_h_q <= cfg_q.font_mode ? 16'(cfg_q.scale_y) * 16'(cfg_q.line_advance)
				: 16'(cfg_q.scale_y) * 16'(tbl_pkg::CLASSIC_H);
			classic_adv_q <= 11'(cfg_q.scale_x) * 11'(tbl_pkg::CLASSIC_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind <= s_tuser;
			item_s1.origin_x <= s_tdata[15:0];
			item_s1.origin_y <= s_tdata[31:16];
			item_s1.box_width <= s_tdata[46:32];
			item_s1.box_height <= s_tdata[61:47];
			item_s1.char_code <= s_tdata[69:62];
			item_s1.glyph_width <= s_tdata[77:70];
			item_s1.glyph_height <= s_tdata[85:78];
			item_s1.glyph_x_offset <= s_tdata[93:86];
			item_s1.glyph_x_advance <= s_tdata[101:94];
		end
	end

	tbl_step u_step (
		.it          (item_s1),
		.st          (st_q),
		.cfg         (cfg_q),
		.line_h      (line_h_q),
		.classic_adv (classic_adv_q),
		.res         (res_c),
		.nxt         (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.cursor_x <= '0;
			st_q.cursor_y <= '0;
			st_q.left_edge <= '0;
			st_q.right_edge <= '0;
			st_q.bottom_edge <= '0;
			st_q.halted <= 1'b1;
			valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				st_q <= st_nxt;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {res_q.draw_code, res_q.draw_y, res_q.draw_x};
	assign m_tuser = res_q.status;

endmodule

`default_nettype wire
